/* hdl/tts_pkg.sv */
// Package for the thermistor temperature smoother.
// Holds the register codes, sequencer states, constants and helper functions.
// No dependencies.
`default_nettype none
package tts_pkg;

	typedef enum logic [2:0] {
		REG_SERIES  = 3'd0,
		REG_SUPPLY  = 3'd1,
		REG_NOMINAL = 3'd2,
		REG_BETA    = 3'd3,
		REG_PERIOD  = 3'd4,
		REG_TCONST  = 3'd5
	} cfg_idx_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_LOG,
		ST_LN0,
		ST_LN1,
		ST_LN2,
		ST_LN3,
		ST_LN4,
		ST_P0,
		ST_P1,
		ST_P2,
		ST_DIV,
		ST_POST,
		ST_WDIV,
		ST_SM0,
		ST_SM1,
		ST_SM2,
		ST_SDIV,
		ST_OUT
	} state_t;

	localparam int CFG_W = 20;
	localparam logic [31:0] LN2_Q24 = 32'd11629080;
	localparam logic [31:0] T0_X100 = 32'd29815;
	localparam logic [31:0] BETA_SCALE = 32'd100;
	localparam logic signed [17:0] TMAX = 18'sd131071;
	localparam logic signed [17:0] TMIN = 18'sh20000;
	localparam logic signed [47:0] BIAS17 = 48'sd131072;

	function automatic logic signed [17:0] sat18(input logic signed [47:0] v);
		logic signed [17:0] r;
		if (v > 48'(TMAX)) begin
			r = TMAX;
		end else if (v < 48'(TMIN)) begin
			r = TMIN;
		end else begin
			r = v[17:0];
		end
		return r;
	endfunction

	// Position of the leading one of a nonzero 20-bit value.
	function automatic logic [4:0] lead_one20(input logic [19:0] x);
		logic [4:0] n;
		n = '0;
		for (int i = 0; i < 20; i++) begin
			if (x[i]) begin
				n = 5'(i);
			end
		end
		return n;
	endfunction

endpackage
`default_nettype wire

/* hdl/tts_if.sv */
// Channel interfaces for the thermistor temperature smoother.
// Depends on nothing; carries valid, ready and the word payload.
`default_nettype none
interface tts_in_if;
	logic        valid;
	logic        ready;
	logic [11:0] voltage_mv;
	modport source (output valid, output voltage_mv, input ready);
	modport sink (input valid, input voltage_mv, output ready);
endinterface

interface tts_out_if;
	logic               valid;
	logic               ready;
	logic signed [17:0] smoothed_temp;
	logic signed [17:0] instant_temp;
	logic               ready_res;
	logic               fault;
	modport source (output valid, output smoothed_temp, output instant_temp,
		output ready_res, output fault, input ready);
	modport sink (input valid, input smoothed_temp, input instant_temp,
		input ready_res, input fault, output ready);
endinterface
`default_nettype wire

/* hdl/tts_mul.sv */
// Shared 32x32 unsigned multiplier with a registered product.
// Used by the sequencer for log squaring and all scaling products.
`default_nettype none
module tts_mul (
	input  wire logic        clk,
	input  wire logic [31:0] a,
	input  wire logic [31:0] b,
	output logic      [63:0] prod_q
);
	always_ff @(posedge clk) begin
		prod_q <= 64'(a) * 64'(b);
	end
endmodule
`default_nettype wire

/* hdl/tts_div.sv */
// Restoring divider, one quotient bit per cycle.
// Standalone; takes start with operands and pulses done when quotient is final.
`default_nettype none
module tts_div #(
	parameter int NW = 68,
	parameter int DW = 52
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] dividend,
	input  wire logic [DW-1:0] divisor,
	output logic               done_q,
	output logic      [NW-1:0] quo_q
);
	localparam int CW = $clog2(NW + 1);

	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] dsr_q;
	logic [DW:0]   trial;
	logic          ge;
	logic [DW:0]   diff;

	always_comb begin
		trial = {rem_q, quo_q[NW-1]};
		ge    = trial >= {1'b0, dsr_q};
		diff  = trial - {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
			quo_q <= {quo_q[NW-2:0], ge};
		end
	end
endmodule
`default_nettype wire

/* hdl/thermistor_temperature_smoother_top.sv */
// A good sample runs four base-2 logarithms by repeated squaring on the shared multiplier,
// then the Beta-equation quotient goes through the bit-serial divider, and after warm-up
// the smoothing step takes a second pass through that divider. The warm-up mean is a single
// reciprocal multiplication. A faulted sample goes straight from idle to the output state.
// A word that is not yet taken holds the sequencer in its output state while it waits.
// The input is taken only while the sequencer is idle; a finished word waits in the
// output register, so the next sample may be accepted before it is taken.
// Depends on tts_pkg, tts_if, tts_mul and tts_div.
`default_nettype none
module thermistor_temperature_smoother_top #(
	parameter int WARMUP_SAMPLES = 10,
	parameter int FRAC_BITS = 8
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	tts_in_if.sink                       in_ch,
	tts_out_if.source                    out_ch,
	input  wire logic                    cfg_we,
	input  wire logic [2:0]              cfg_idx,
	input  wire logic [tts_pkg::CFG_W-1:0] cfg_wdata
);
	import tts_pkg::*;

	localparam int K  = 31 + FRAC_BITS;
	localparam int NW = 29 + K;
	localparam int DW = 52;
	localparam logic signed [47:0] K0 = 48'(((27315 << FRAC_BITS) + 50) / 100);
	localparam logic [6:0] WCNT = 7'(WARMUP_SAMPLES);
	// Reciprocal of the warm-up count, exact for dividends below 2^25.
	localparam int WSH = 25 + $clog2(WARMUP_SAMPLES);
	localparam logic [63:0] WREC_FULL = ((64'd1 << WSH) + 64'(WARMUP_SAMPLES) - 64'd1)
		/ 64'(WARMUP_SAMPLES);
	localparam logic [31:0] WREC = WREC_FULL[31:0];

	// Configuration registers.
	logic [19:0] series_q, nominal_q, tconst_q;
	logic [12:0] supply_q;
	logic [13:0] beta_q;
	logic [15:0] period_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			series_q  <= 20'd100000;
			supply_q  <= 13'd3300;
			nominal_q <= 20'd100000;
			beta_q    <= 14'd4303;
			period_q  <= 16'd100;
			tconst_q  <= 20'd60000;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_SERIES:  series_q  <= cfg_wdata[19:0];
				REG_SUPPLY:  supply_q  <= cfg_wdata[12:0];
				REG_NOMINAL: nominal_q <= cfg_wdata[19:0];
				REG_BETA:    beta_q    <= cfg_wdata[13:0];
				REG_PERIOD:  period_q  <= cfg_wdata[15:0];
				REG_TCONST:  tconst_q  <= cfg_wdata[19:0];
				default: ;
			endcase
		end
	end

	state_t state_q, state_d;

	logic [11:0]        v_q;
	logic               bad_q;
	logic [1:0]         log_idx_q;
	logic [4:0]         it_q;
	logic [28:0]        frac_q;
	logic [35:0]        pos_q, neg_q, mag_q, lnmag_q;
	logic               sign_q;
	logic [63:0]        acc_q;
	logic [50:0]        a_q;
	logic [28:0]        num_q;
	logic signed [17:0] t_q, running_q;
	logic signed [23:0] sum_q;
	logic [6:0]         count_q;
	logic               ready_q;

	logic               out_valid_q;
	logic signed [17:0] out_smooth_q, out_inst_q;
	logic               out_ready_q, out_fault_q;

	logic [31:0]   mul_a, mul_b;
	logic [63:0]   prod;
	logic          div_start, div_done;
	logic [NW-1:0] div_dividend, quot;
	logic [DW-1:0] div_divisor;

	tts_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod_q(prod));

	tts_div #(.NW(NW), .DW(DW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_dividend),
		.divisor(div_divisor), .done_q(div_done), .quo_q(quot)
	);

	// Log operand and squaring step.
	logic [19:0] lx;
	logic [4:0]  ln_n;
	logic [30:0] m0, m_next;
	logic        sq_bit;
	logic [34:0] log_val;

	always_comb begin
		case (log_idx_q)
			2'd0:    lx = series_q;
			2'd1:    lx = {7'b0, supply_q - {1'b0, v_q}};
			2'd2:    lx = {8'b0, v_q};
			default: lx = nominal_q;
		endcase
		ln_n    = lead_one20(lx);
		m0      = 31'({11'b0, lx} << (5'd30 - ln_n));
		sq_bit  = prod[61];
		m_next  = sq_bit ? prod[61:31] : prod[60:30];
		log_val = {ln_n, frac_q, sq_bit};
	end

	// Denominator of the Beta equation.
	logic [63:0] p_full;
	logic [51:0] p_c, den_c;
	logic        inf_c;

	always_comb begin
		p_full = acc_q + {prod[31:0], 32'b0};
		p_c    = p_full[51:0];
		den_c  = sign_q ? ({1'b0, a_q} - p_c) : ({1'b0, a_q} + p_c);
		inf_c  = sign_q ? (p_c >= {1'b0, a_q}) : (den_c == '0);
	end

	// Kelvin to Celsius from the quotient.
	logic [41:0]        tk_sum;
	logic signed [17:0] t_div;

	always_comb begin
		tk_sum = 42'(quot[40:0]) + 42'd1;
		if (|quot[NW-1:40]) begin
			t_div = TMAX;
		end else begin
			t_div = sat18($signed({7'b0, tk_sum[41:1]}) - K0);
		end
	end

	// Warm-up and smoothing arithmetic.
	logic signed [23:0] sum_c;
	logic signed [26:0] bias_c;
	logic [20:0]        sden_c;
	logic [17:0]        pb, tb;
	logic signed [17:0] run_c;
	logic [25:0]        wq_c;
	logic signed [17:0] run_w;

	always_comb begin
		sum_c  = sum_q + 24'(t_q);
		bias_c = 27'(sum_c) + (27'(WCNT) <<< 17);
		sden_c = 21'(period_q) + 21'(tconst_q);
		pb     = {~running_q[17], running_q[16:0]};
		tb     = {~t_q[17], t_q[16:0]};
		run_c  = sat18($signed({22'b0, quot[25:0]}) - BIAS17);
		wq_c   = 26'(prod >> WSH);
		run_w  = sat18($signed({22'b0, wq_c}) - BIAS17);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_ch.valid) begin
					if (in_ch.voltage_mv == '0 || {1'b0, in_ch.voltage_mv} >= supply_q
						|| series_q == '0 || nominal_q == '0) begin
						state_d = ST_OUT;
					end else begin
						state_d = ST_LOG;
					end
				end
			end
			ST_LOG: begin
				if (it_q == 5'd30 && log_idx_q == 2'd3) begin
					state_d = ST_LN0;
				end
			end
			ST_LN0: state_d = ST_LN1;
			ST_LN1: state_d = ST_LN2;
			ST_LN2: state_d = ST_LN3;
			ST_LN3: state_d = ST_LN4;
			ST_LN4: state_d = ST_P0;
			ST_P0:  state_d = ST_P1;
			ST_P1:  state_d = ST_P2;
			ST_P2:  state_d = inf_c ? ST_POST : ST_DIV;
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_POST;
				end
			end
			ST_POST: begin
				if (!ready_q) begin
					state_d = (count_q + 7'd1 >= WCNT) ? ST_WDIV : ST_OUT;
				end else begin
					state_d = (sden_c == '0) ? ST_OUT : ST_SM0;
				end
			end
			ST_WDIV: state_d = ST_OUT;
			ST_SM0: state_d = ST_SM1;
			ST_SM1: state_d = ST_SM2;
			ST_SM2: state_d = ST_SDIV;
			ST_SDIV: begin
				if (div_done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!out_valid_q || out_ch.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Unit operands and handshake.
	always_comb begin
		mul_a        = '0;
		mul_b        = '0;
		div_start    = 1'b0;
		div_dividend = '0;
		div_divisor  = '0;
		in_ch.ready  = 1'b0;
		unique case (state_q)
			ST_IDLE: in_ch.ready = 1'b1;
			ST_LOG: begin
				mul_a = {1'b0, (it_q == '0) ? m0 : m_next};
				mul_b = mul_a;
			end
			ST_LN1: begin
				mul_a = mag_q[31:0];
				mul_b = LN2_Q24;
			end
			ST_LN2: begin
				mul_a = {28'b0, mag_q[35:32]};
				mul_b = LN2_Q24;
			end
			ST_LN3: begin
				mul_a = BETA_SCALE;
				mul_b = {18'b0, beta_q};
			end
			ST_LN4: begin
				mul_a = T0_X100;
				mul_b = {18'b0, beta_q};
			end
			ST_P0: begin
				mul_a = lnmag_q[31:0];
				mul_b = T0_X100;
			end
			ST_P1: begin
				mul_a = {28'b0, lnmag_q[35:32]};
				mul_b = T0_X100;
			end
			ST_P2: begin
				div_start    = !inf_c;
				div_dividend = {num_q, {K{1'b0}}};
				div_divisor  = den_c;
			end
			ST_POST: begin
				// Rounded mean: floor((biased sum + count/2) / count).
				mul_a = {6'b0, bias_c[25:0]} + 32'(WCNT >> 1);
				mul_b = WREC;
			end
			ST_SM0: begin
				mul_a = {14'b0, pb};
				mul_b = {12'b0, tconst_q};
			end
			ST_SM1: begin
				mul_a = {14'b0, tb};
				mul_b = {16'b0, period_q};
			end
			ST_SM2: begin
				div_start    = 1'b1;
				div_dividend = NW'(acc_q) + NW'(prod) + NW'(sden_c >> 1);
				div_divisor  = DW'(sden_c);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			running_q   <= '0;
			sum_q       <= '0;
			count_q     <= '0;
			ready_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_OUT && (!out_valid_q || out_ch.ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_POST: begin
					if (!ready_q) begin
						sum_q   <= sum_c;
						count_q <= count_q + 7'd1;
					end
				end
				ST_WDIV: begin
					running_q <= run_w;
					sum_q     <= '0;
					count_q   <= WCNT;
					ready_q   <= 1'b1;
				end
				ST_SDIV: begin
					if (div_done) begin
						running_q <= run_c;
					end
				end
				default: ;
			endcase
		end
	end

	// Datapath registers without reset.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				v_q       <= in_ch.voltage_mv;
				bad_q     <= in_ch.voltage_mv == '0 || {1'b0, in_ch.voltage_mv} >= supply_q
					|| series_q == '0 || nominal_q == '0;
				t_q       <= '0;
				log_idx_q <= '0;
				it_q      <= '0;
				pos_q     <= '0;
				neg_q     <= '0;
			end
			ST_LOG: begin
				if (it_q != '0) begin
					frac_q <= {frac_q[27:0], sq_bit};
				end
				if (it_q == 5'd30) begin
					it_q      <= '0;
					log_idx_q <= log_idx_q + 2'd1;
					if (log_idx_q[1] == 1'b0) begin
						pos_q <= pos_q + 36'(log_val);
					end else begin
						neg_q <= neg_q + 36'(log_val);
					end
				end else begin
					it_q <= it_q + 5'd1;
				end
			end
			ST_LN0: begin
				sign_q <= neg_q > pos_q;
				mag_q  <= (neg_q > pos_q) ? neg_q - pos_q : pos_q - neg_q;
			end
			ST_LN2: acc_q <= prod;
			ST_LN3: acc_q <= acc_q + {prod[31:0], 32'b0};
			ST_LN4: begin
				a_q     <= {prod[20:0], 30'b0};
				lnmag_q <= 36'((acc_q + 64'h80_0000) >> 24);
			end
			ST_P0: num_q <= prod[28:0];
			ST_P1: acc_q <= prod;
			ST_P2: begin
				if (inf_c) begin
					t_q <= TMAX;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					t_q <= t_div;
				end
			end
			ST_SM1: acc_q <= prod;
			ST_OUT: begin
				if (!out_valid_q || out_ch.ready) begin
					out_smooth_q <= running_q;
					out_inst_q   <= t_q;
					out_ready_q  <= ready_q;
					out_fault_q  <= bad_q;
				end
			end
			default: ;
		endcase
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.smoothed_temp = out_smooth_q;
	assign out_ch.instant_temp  = out_inst_q;
	assign out_ch.ready_res     = out_ready_q;
	assign out_ch.fault         = out_fault_q;
endmodule
`default_nettype wire

/* hdl/tts_chk.sv */
// Port-level checker for the thermistor temperature smoother.
// Bound to thermistor_temperature_smoother_top; sees only its ports.
`default_nettype none
module tts_chk (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_ready,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic signed [17:0] smoothed_temp,
	input wire logic signed [17:0] instant_temp,
	input wire logic               ready_res,
	input wire logic               fault
);
	// A word that is shown must stay until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output word dropped before it was taken");

	// The sequencer works on one sample at a time.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again while a sample is in work");

	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fault |-> instant_temp == '0)
		else $error("faulted word carries a temperature");

	// Before warm-up completes the running value is still at its reset value.
	a_warm_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !ready_res |-> smoothed_temp == '0)
		else $error("smoothed value moved before warm-up completed");
endmodule

bind thermistor_temperature_smoother_top tts_chk u_tts_chk (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_ch.valid),
	.in_ready(in_ch.ready),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.smoothed_temp(out_ch.smoothed_temp),
	.instant_temp(out_ch.instant_temp),
	.ready_res(out_ch.ready_res),
	.fault(out_ch.fault)
);
`default_nettype wire

/* bench/thermistor_temperature_smoother_top_tb.sv */
// Self-checking testbench for the thermistor temperature smoother.
// Depends on tts_pkg, tts_if and the top level; predicts each word in fixed point.
`default_nettype none
module thermistor_temperature_smoother_top_tb;
	import tts_pkg::*;

	localparam int WARMUP = 10;
	localparam int FB = 8;
	localparam longint CYCLE_LIMIT = 64'd3000000;

	typedef struct packed {
		logic signed [17:0] smoothed_temp;
		logic signed [17:0] instant_temp;
		logic               ready_res;
		logic               fault;
	} temp_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_idx = '0;
	logic [CFG_W-1:0] cfg_wdata = '0;

	tts_in_if in_ch ();
	tts_out_if out_ch ();

	thermistor_temperature_smoother_top #(.WARMUP_SAMPLES(WARMUP), .FRAC_BITS(FB)) dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
	);

	// Predictor copy of the registers and the filter state.
	longint unsigned m_series, m_supply, m_nominal, m_beta, m_period, m_tconst;
	longint m_running, m_wsum;
	int m_wcount;
	bit m_ready;

	temp_word_t expected_words[$];
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int mismatches = 0;
	longint cycles = 0;

	initial begin
		in_ch.valid = 1'b0;
		in_ch.voltage_mv = '0;
		out_ch.ready = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic longint unsigned log2_q30(longint unsigned x);
		longint unsigned n, m, frac;
		n = 0;
		frac = 0;
		while (n < 40 && (x >> (n + 1)) != 0) n++;
		m = x << (30 - n);
		for (int i = 29; i >= 0; i--) begin
			m = (m * m) >> 30;
			if (m >= (64'd2 << 30)) begin
				m >>= 1;
				frac |= 64'd1 << i;
			end
		end
		return (n << 30) | frac;
	endfunction

	function automatic longint clip18(longint v);
		if (v > 131071) return 131071;
		if (v < -131072) return -131072;
		return v;
	endfunction

	function automatic longint kelvin_to_celsius_q(longint unsigned v);
		longint unsigned pos, neg, mag, lnmag, a, p, den, num, q, r, tk, k0;
		bit negative;
		pos = log2_q30(m_series) + log2_q30(m_supply - v);
		neg = log2_q30(v) + log2_q30(m_nominal);
		negative = neg > pos;
		mag = negative ? neg - pos : pos - neg;
		lnmag = (mag * 64'd11629080 + (64'd1 << 23)) >> 24;
		a = (64'd100 * m_beta) << 30;
		p = 64'd29815 * lnmag;
		if (negative) begin
			if (p >= a) return 131071;
			den = a - p;
		end else begin
			den = a + p;
		end
		if (den == 0) return 131071;
		num = m_beta * 64'd29815;
		q = num / den;
		r = num % den;
		for (int i = 0; i < 31 + FB; i++) begin
			if (q >= (64'd1 << 40)) return 131071;
			r <<= 1;
			q <<= 1;
			if (r >= den) begin
				r -= den;
				q |= 1;
			end
		end
		if (q >= (64'd1 << 40)) return 131071;
		tk = (q + 1) >> 1;
		k0 = ((64'd27315 << FB) + 50) / 100;
		return clip18(longint'(tk) - longint'(k0));
	endfunction

	function automatic temp_word_t predict_temp_word(longint unsigned v);
		temp_word_t w;
		longint t;
		longint unsigned den, pb, tb, num, qq;
		bit bad;
		t = 0;
		bad = (v == 0) || (v >= m_supply) || m_series == 0 || m_nominal == 0;
		if (!bad) begin
			t = kelvin_to_celsius_q(v);
			if (!m_ready) begin
				m_wsum += t;
				m_wcount++;
				if (m_wcount >= WARMUP) begin
					pb = longint'(m_wsum + (longint'(WARMUP) << 17));
					qq = (2 * pb + WARMUP) / (2 * WARMUP);
					m_running = clip18(longint'(qq) - (64'sd1 << 17));
					m_wsum = 0;
					m_wcount = WARMUP;
					m_ready = 1'b1;
				end
			end else begin
				den = m_period + m_tconst;
				if (den != 0) begin
					pb = longint'(m_running + (64'sd1 << 17));
					tb = longint'(t + (64'sd1 << 17));
					num = pb * m_tconst + tb * m_period;
					qq = (num + den / 2) / den;
					m_running = clip18(longint'(qq) - (64'sd1 << 17));
				end
			end
		end
		w.smoothed_temp = m_running[17:0];
		w.instant_temp = t[17:0];
		w.ready_res = m_ready;
		w.fault = bad;
		return w;
	endfunction

	// Result checker with random backpressure.
	always @(posedge clk) begin
		temp_word_t got, want;
		if (out_ch.valid && out_ch.ready) begin
			got = '{out_ch.smoothed_temp, out_ch.instant_temp, out_ch.ready_res, out_ch.fault};
			if (expected_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected word %h", got);
			end else begin
				want = expected_words.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected smooth %0d inst %0d rdy %b flt %b, got %0d %0d %b %b",
							want.smoothed_temp, want.instant_temp, want.ready_res, want.fault,
							got.smoothed_temp, got.instant_temp, got.ready_res, got.fault);
				end
			end
		end
		if (arst_n) out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Valid stays high after an accept until the next send or drain decides its value.
	task automatic send_sample(input logic [11:0] v);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.voltage_mv <= v;
		expected_words.push_back(predict_temp_word(v));
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
	endtask

	task automatic drain_words();
		in_ch.valid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input longint unsigned value);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= value[CFG_W-1:0];
		@(posedge clk);
		case (idx)
			REG_SERIES: m_series = value & 20'hFFFFF;
			REG_SUPPLY: m_supply = value & 13'h1FFF;
			REG_NOMINAL: m_nominal = value & 20'hFFFFF;
			REG_BETA: m_beta = value & 14'h3FFF;
			REG_PERIOD: m_period = value & 16'hFFFF;
			REG_TCONST: m_tconst = value & 20'hFFFFF;
			default: ;
		endcase
	endtask

	task automatic set_divider(input longint unsigned rs, vs, rn, b, per, tc);
		drain_words();
		write_reg(REG_SERIES, rs);
		write_reg(REG_SUPPLY, vs);
		write_reg(REG_NOMINAL, rn);
		write_reg(REG_BETA, b);
		write_reg(REG_PERIOD, per);
		write_reg(REG_TCONST, tc);
		cfg_we <= 1'b0;
	endtask

	task automatic test_directed_edges();
		logic [11:0] list [$] = '{12'd0, 12'd1, 12'd4095, 12'd3299, 12'd3300, 12'd1650,
			12'd2, 12'd100, 12'd3000, 12'd1000, 12'd2048, 12'd500, 12'd2500, 12'd1650};
		foreach (list[i]) send_sample(list[i]);
		// Pause until every word is back before sending again.
		drain_words();
		send_sample(12'd1650);
		send_sample(12'hAAA);
		send_sample(12'h555);
	endtask

	task automatic test_register_extremes();
		set_divider(1000, 5000, 1000000, 10000, 65535, 1);
		for (int i = 0; i < 4; i++) send_sample(12'(1 + i * 1300));
		set_divider(1000000, 1000, 1000, 1000, 1, 1000000);
		send_sample(12'd1);
		send_sample(12'd999);
		send_sample(12'd500);
		set_divider(0, 4095, 0, 0, 0, 0);
		send_sample(12'd100);
		set_divider(100000, 8191, 100000, 16383, 0, 0);
		send_sample(12'd4095);
		send_sample(12'd1);
	endtask

	task automatic test_random_samples(input int count);
		for (int i = 0; i < count; i++) begin
			if (i % 300 == 299)
				set_divider($urandom_range(1000000, 1000), $urandom_range(5000, 1000),
					$urandom_range(1000000, 1000), $urandom_range(10000, 1000),
					$urandom_range(65535, 1), $urandom_range(1000000, 1));
			if ($urandom_range(9) == 0) send_sample(12'($urandom()));
			else send_sample(12'($urandom_range(m_supply > 1 ? m_supply - 1 : 1, 1)));
		end
	endtask

	initial begin
		m_series = 100000; m_supply = 3300; m_nominal = 100000; m_beta = 4303;
		m_period = 100; m_tconst = 60000;
		m_running = 0; m_wsum = 0; m_wcount = 0; m_ready = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 10;
		recv_idle_pct = 84;
		test_directed_edges();
		test_register_extremes();
		set_divider(100000, 3300, 100000, 4303, 100, 60000);
		test_random_samples(600);
		send_idle_pct = 84;
		recv_idle_pct = 10;
		test_random_samples(600);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_samples(600);
		drain_words();
		if (mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule
`default_nettype wire
